FILE: rtl/core/mops_pkg.sv
// Shared types, constants and helpers of the Morton-order point sorter.
`default_nettype none
package mops_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int AXIS_BITS  = 21;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 32;
  localparam int OFF_W      = COORD_W + 1;
  localparam int PROD_W     = OFF_W + AXIS_BITS;
  localparam int KEY_W      = 3 * AXIS_BITS;
  localparam int STEP_W     = $clog2(AXIS_BITS + 1);
  localparam int OUT_BITS   = IDX_W + KEY_W + 3 * COORD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_DATA_W  = 3 * COORD_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    logic                      final_pt;
  } mops_item_t;

  // Interleave three axis codes: x bit b at 3b, y at 3b+1, z at 3b+2.
  function automatic logic [KEY_W-1:0] interleave(input logic [AXIS_BITS-1:0] qx,
                                                  input logic [AXIS_BITS-1:0] qy,
                                                  input logic [AXIS_BITS-1:0] qz);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int b = 0; b < AXIS_BITS; b++) begin
      k[3*b]     = qx[b];
      k[3*b + 1] = qy[b];
      k[3*b + 2] = qz[b];
    end
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mops_front.sv
// Front end: accepts command transactions into a two-entry queue.
`default_nettype none
module mops_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [mops_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tuser,
  input  wire logic                 in_tlast,
  output logic                      q_valid,
  output mops_pkg::mops_item_t      q_item,
  input  wire logic                 q_pop
);
  import mops_pkg::*;

  mops_item_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{cmd: in_tuser,
                            z: in_tdata[3*COORD_W-1:2*COORD_W],
                            y: in_tdata[2*COORD_W-1:COORD_W],
                            x: in_tdata[COORD_W-1:0],
                            final_pt: in_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mops_back.sv
// Back end: point stores, bounding box, quantizer, insertion sorter, fetch.
`default_nettype none
module mops_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire mops_pkg::mops_item_t q_item,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [mops_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import mops_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_Q_RD  = 4'd1;
  localparam logic [3:0] S_Q_OFF = 4'd2;
  localparam logic [3:0] S_Q_N   = 4'd3;
  localparam logic [3:0] S_Q_DIV = 4'd4;
  localparam logic [3:0] S_Q_KEY = 4'd5;
  localparam logic [3:0] S_I_RD  = 4'd6;
  localparam logic [3:0] S_I_CMP = 4'd7;
  localparam logic [3:0] S_F_RD  = 4'd8;
  localparam logic [3:0] S_F_IDX = 4'd9;
  localparam logic [3:0] S_F_OUT = 4'd10;

  localparam int SRT_W = KEY_W + IDX_W;
  localparam logic signed [COORD_W-1:0] MOST_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MOST_NEG = {1'b1, {(COORD_W-1){1'b0}}};

  logic [3:0]                state_r;
  logic [CNT_W-1:0]          count_r, fp_r;
  logic                      sorted_r;
  logic signed [COORD_W-1:0] bmin_r [3];
  logic signed [COORD_W-1:0] bmax_r [3];
  logic [IDX_W-1:0]          i_r, j_r;
  logic [OFF_W-1:0]          off_r [3];
  logic [OFF_W-1:0]          ext_r [3];
  logic [OFF_W-1:0]          rem_r [3];
  logic [AXIS_BITS-1:0]      nlo_r [3];
  logic [AXIS_BITS-1:0]      quo_r [3];
  logic [STEP_W-1:0]         step_r;
  logic [KEY_W-1:0]          cur_key_r;
  logic [KEY_W-1:0]          fkey_r;
  logic [IDX_W-1:0]          fidx_r;
  logic                      out_valid_r, out_last_r;
  logic [OUT_BITS-1:0]       out_data_r;

  // Storage.
  logic signed [COORD_W-1:0] cx_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] cy_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] cz_mem [MAX_POINTS];
  logic [SRT_W-1:0]          srt_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] co_rd_r [3];
  logic [SRT_W-1:0]          srt_rd_r;

  // Load path, with the set cleared first when a sorted set is present.
  logic [CNT_W-1:0]          eff_cnt;
  logic signed [COORD_W-1:0] emin [3];
  logic signed [COORD_W-1:0] emax [3];
  logic signed [COORD_W-1:0] in_c [3];
  logic                      is_load, room, co_we;
  logic [CNT_W-1:0]          new_cnt;
  logic [IDX_W-1:0]          co_raddr, srt_raddr, srt_waddr;
  logic                      srt_we;
  logic [SRT_W-1:0]          srt_wdata;
  logic [PROD_W-1:0]         prod [3];
  logic [OFF_W:0]            trial [3];
  logic [AXIS_BITS-1:0]      qv [3];
  logic                      fetch_ok, last_pt;

  assign in_c[0] = q_item.x;
  assign in_c[1] = q_item.y;
  assign in_c[2] = q_item.z;
  assign is_load = (q_item.cmd == CMD_LOAD);
  assign eff_cnt = sorted_r ? '0 : count_r;
  assign room    = (eff_cnt < CNT_W'(MAX_POINTS));
  assign new_cnt = room ? eff_cnt + CNT_W'(1) : eff_cnt;
  assign co_we   = (state_r == S_IDLE) && q_valid && is_load && room;
  assign fetch_ok = sorted_r && (fp_r < count_r);
  assign last_pt  = ({1'b0, i_r} + CNT_W'(1)) == count_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      emin[a] = sorted_r ? MOST_POS : bmin_r[a];
      emax[a] = sorted_r ? MOST_NEG : bmax_r[a];
      prod[a] = {off_r[a], {AXIS_BITS{1'b0}}} - {{AXIS_BITS{1'b0}}, off_r[a]};
      trial[a] = {rem_r[a], nlo_r[a][AXIS_BITS-1]};
      qv[a] = (ext_r[a] == '0) ? '0 : quo_r[a];
    end
  end

  always_comb begin
    q_pop = 1'b0;
    if (state_r == S_IDLE && q_valid) begin
      if (is_load) q_pop = 1'b1;
      else if (!fetch_ok || !out_valid_r) q_pop = 1'b1;
    end
  end

  assign co_raddr  = (state_r == S_Q_RD) ? i_r : srt_rd_r[IDX_W-1:0];
  assign srt_raddr = (state_r == S_F_RD) ? fp_r[IDX_W-1:0] : j_r - IDX_W'(1);

  always_comb begin
    srt_we    = 1'b0;
    srt_waddr = j_r;
    srt_wdata = {cur_key_r, i_r};
    if (state_r == S_I_RD && j_r == '0) begin
      srt_we = 1'b1;
    end else if (state_r == S_I_CMP) begin
      srt_we = 1'b1;
      if (srt_rd_r[SRT_W-1:IDX_W] > cur_key_r) srt_wdata = srt_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (co_we) begin
      cx_mem[eff_cnt[IDX_W-1:0]] <= q_item.x;
      cy_mem[eff_cnt[IDX_W-1:0]] <= q_item.y;
      cz_mem[eff_cnt[IDX_W-1:0]] <= q_item.z;
    end
    co_rd_r[0] <= cx_mem[co_raddr];
    co_rd_r[1] <= cy_mem[co_raddr];
    co_rd_r[2] <= cz_mem[co_raddr];
  end

  always_ff @(posedge clk) begin
    if (srt_we) srt_mem[srt_waddr] <= srt_wdata;
    srt_rd_r <= srt_mem[srt_raddr];
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_Q_OFF: begin
        for (int a = 0; a < 3; a++) begin
          off_r[a] <= {co_rd_r[a][COORD_W-1], co_rd_r[a]} - {bmin_r[a][COORD_W-1], bmin_r[a]};
          ext_r[a] <= {bmax_r[a][COORD_W-1], bmax_r[a]} - {bmin_r[a][COORD_W-1], bmin_r[a]};
        end
      end
      S_Q_N: begin
        for (int a = 0; a < 3; a++) begin
          rem_r[a] <= prod[a][PROD_W-1:AXIS_BITS];
          nlo_r[a] <= prod[a][AXIS_BITS-1:0];
          quo_r[a] <= '0;
        end
      end
      S_Q_DIV: begin
        for (int a = 0; a < 3; a++) begin
          if (trial[a] >= {1'b0, ext_r[a]}) begin
            rem_r[a] <= OFF_W'(trial[a] - {1'b0, ext_r[a]});
            quo_r[a] <= {quo_r[a][AXIS_BITS-2:0], 1'b1};
          end else begin
            rem_r[a] <= trial[a][OFF_W-1:0];
            quo_r[a] <= {quo_r[a][AXIS_BITS-2:0], 1'b0};
          end
          nlo_r[a] <= {nlo_r[a][AXIS_BITS-2:0], 1'b0};
        end
      end
      S_Q_KEY: cur_key_r <= interleave(qv[0], qv[1], qv[2]);
      S_F_IDX: begin
        fkey_r <= srt_rd_r[SRT_W-1:IDX_W];
        fidx_r <= srt_rd_r[IDX_W-1:0];
      end
      S_F_OUT: out_data_r <= {co_rd_r[2], co_rd_r[1], co_rd_r[0], fkey_r, fidx_r};
      default: ;
    endcase
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fp_r        <= '0;
      sorted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      step_r      <= '0;
      for (int a = 0; a < 3; a++) begin
        bmin_r[a] <= MOST_POS;
        bmax_r[a] <= MOST_NEG;
      end
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && is_load) begin
            for (int a = 0; a < 3; a++) begin
              bmin_r[a] <= (room && in_c[a] < emin[a]) ? in_c[a] : emin[a];
              bmax_r[a] <= (room && in_c[a] > emax[a]) ? in_c[a] : emax[a];
            end
            count_r  <= new_cnt;
            fp_r     <= '0;
            sorted_r <= 1'b0;
            i_r      <= '0;
            if (q_item.final_pt) begin
              if (new_cnt == '0) sorted_r <= 1'b1;
              else state_r <= S_Q_RD;
            end
          end else if (q_valid && fetch_ok && !out_valid_r) begin
            state_r <= S_F_RD;
          end
        end
        S_Q_RD:  state_r <= S_Q_OFF;
        S_Q_OFF: state_r <= S_Q_N;
        S_Q_N: begin
          step_r  <= '0;
          state_r <= S_Q_DIV;
        end
        S_Q_DIV: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(AXIS_BITS - 1)) state_r <= S_Q_KEY;
        end
        S_Q_KEY: begin
          j_r     <= i_r;
          state_r <= S_I_RD;
        end
        S_I_RD: begin
          if (j_r != '0) begin
            state_r <= S_I_CMP;
          end else if (last_pt) begin
            sorted_r <= 1'b1;
            fp_r     <= '0;
            state_r  <= S_IDLE;
          end else begin
            i_r     <= i_r + IDX_W'(1);
            state_r <= S_Q_RD;
          end
        end
        S_I_CMP: begin
          if (srt_rd_r[SRT_W-1:IDX_W] > cur_key_r) begin
            j_r     <= j_r - IDX_W'(1);
            state_r <= S_I_RD;
          end else if (last_pt) begin
            sorted_r <= 1'b1;
            fp_r     <= '0;
            state_r  <= S_IDLE;
          end else begin
            i_r     <= i_r + IDX_W'(1);
            state_r <= S_Q_RD;
          end
        end
        S_F_RD:  state_r <= S_F_IDX;
        S_F_IDX: state_r <= S_F_OUT;
        S_F_OUT: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (fp_r + CNT_W'(1)) == count_r;
          fp_r        <= fp_r + CNT_W'(1);
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_data_r};

endmodule
`default_nettype wire

FILE: rtl/core/morton_order_point_sort.sv
// Top level of the Morton-order point sorter.
// Usage: the input channel carries one command per transaction. tuser = 0
// loads a point (x, y, z in tdata, signed Q16.16); tlast on a load marks the
// final point of the set and starts quantization and sorting. tuser = 1
// fetches the next point in ascending Morton order; it yields one result
// transaction, or none before sorting or past the end of the set.
// The input queue holds two transactions. A fetch runs from queue to output
// register through a sorted-order read, a coordinate read and an output load.
// After the final point each stored point is quantized (a radix-2 divider,
// three axes in parallel), then gets its first sorted-memory read, then a read
// and a compare for each position it moves in the insertion sort, which shares
// one read port of the sorted key memory, and one closing compare unless it
// lands at the front. A load arriving after sorting starts a fresh set.
// Reset clears the queue, point count, fetch pointer and bounding box; the
// memories need no clearing since only written entries are ever read.
// When the receiver stalls the result holds in the output register, the
// queue keeps accepting until it is full, and a further fetch waits until
// the output slot is free.
`default_nettype none
module morton_order_point_sort (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // tdata: coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  wire logic [mops_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: command (0 load, 1 fetch)
  input  wire logic                         in_tuser,
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // tdata: source_index [9:0], morton_key [72:10], out_x [104:73],
  //        out_y [136:105], out_z [168:137], zero padding above
  output logic [mops_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import mops_pkg::*;

  mops_item_t q_item;
  logic       q_valid, q_pop;

  mops_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .q_valid, .q_item, .q_pop
  );

  mops_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule
`default_nettype wire

FILE: rtl/core/mops_checker.sv
// Port-level checks of the point sorter and their bind to the top level.
`default_nettype none
module mops_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [mops_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                       out_tlast
);
  import mops_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
    else $error("padding bits not zero");

endmodule

bind morton_order_point_sort mops_checker u_mops_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
`default_nettype wire

FILE: bench/tb_morton_order_point_sort.sv
// Self-checking testbench for the Morton-order point sorter with a predicting scoreboard.
`timescale 1ns / 100ps

// The scoreboard keeps its own copy of the point set, bounding box and sorted order.
// Every accepted input transaction is passed to note_command. A fetch that should
// produce a point queues the expected result. check_point compares each output
// transaction with the oldest expected result.
class morton_scoreboard;
  typedef struct {
    bit [9:0]  src;
    bit [62:0] key;
    bit [31:0] px, py, pz;
    bit        last;
  } sorted_point_t;

  int            xs[1024], ys[1024], zs[1024];
  bit [62:0]     keys[1024];
  int            rank[1024];
  int            lo[3], hi[3];
  int            count, next_rank;
  bit            is_sorted;
  sorted_point_t pending_q[$];
  int            errors;

  function void clear_set();
    for (int a = 0; a < 3; a++) begin
      lo[a] = 32'sh7fffffff;
      hi[a] = 32'sh80000000;
    end
    count = 0;
    next_rank = 0;
    is_sorted = 0;
  endfunction

  function new();
    errors = 0;
    clear_set();
  endfunction

  // Scale one coordinate into the box. An axis with zero extent maps to 0.
  function bit [20:0] scale_axis(int p, int a);
    longint unsigned span, off;
    span = longint'(hi[a]) - longint'(lo[a]);
    off  = longint'(p) - longint'(lo[a]);
    if (span == 0) return 21'd0;
    return 21'((off * ((64'd1 << 21) - 1)) / span);
  endfunction

  function void build_order();
    bit [20:0] q[3];
    int j, cur;
    for (int i = 0; i < count; i++) begin
      q[0] = scale_axis(xs[i], 0);
      q[1] = scale_axis(ys[i], 1);
      q[2] = scale_axis(zs[i], 2);
      keys[i] = '0;
      for (int b = 0; b < 21; b++)
        for (int a = 0; a < 3; a++) keys[i][3*b + a] = q[a][b];
    end
    // Stable insertion sort: equal keys stay in load order.
    for (int i = 0; i < count; i++) begin
      cur = i;
      j = i;
      while (j > 0 && keys[rank[j-1]] > keys[cur]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = cur;
    end
    next_rank = 0;
    is_sorted = 1;
  endfunction

  function void note_command(bit cmd, int x, int y, int z, bit fin);
    sorted_point_t e;
    int idx;
    if (cmd == mops_pkg::CMD_LOAD) begin
      if (is_sorted) clear_set();
      if (count < 1024) begin
        xs[count] = x; ys[count] = y; zs[count] = z;
        if (x < lo[0]) lo[0] = x;
        if (x > hi[0]) hi[0] = x;
        if (y < lo[1]) lo[1] = y;
        if (y > hi[1]) hi[1] = y;
        if (z < lo[2]) lo[2] = z;
        if (z > hi[2]) hi[2] = z;
        count++;
      end
      if (fin) build_order();
    end else if (is_sorted && next_rank < count) begin
      idx = rank[next_rank];
      e.src = idx[9:0];
      e.key = keys[idx];
      e.px = xs[idx]; e.py = ys[idx]; e.pz = zs[idx];
      e.last = (next_rank + 1 == count);
      next_rank++;
      pending_q.insert(pending_q.size(), e);
    end
  endfunction

  function void check_point(bit [175:0] d, bit last);
    sorted_point_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected output transaction: source_index %0d", d[9:0]);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (d[9:0] !== e.src) begin
      $error("source_index: expected %0d, actual %0d", e.src, d[9:0]); errors++;
    end
    if (d[72:10] !== e.key) begin
      $error("morton_key: expected %h, actual %h", e.key, d[72:10]); errors++;
    end
    if (d[104:73] !== e.px) begin
      $error("out_x: expected %h, actual %h", e.px, d[104:73]); errors++;
    end
    if (d[136:105] !== e.py) begin
      $error("out_y: expected %h, actual %h", e.py, d[136:105]); errors++;
    end
    if (d[168:137] !== e.pz) begin
      $error("out_z: expected %h, actual %h", e.pz, d[168:137]); errors++;
    end
    if (last !== e.last) begin
      $error("last_result: expected %0d, actual %0d", e.last, last); errors++;
    end
  endfunction
endclass

module tb_morton_order_point_sort;
  import mops_pkg::*;

  // Longest quiet stretch is the sort of a full store.
  localparam int WATCHDOG_LIMIT = 5_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // coord_x, coord_y, coord_z from bit 0 up
  logic                  in_tuser;   // command
  logic                  in_tlast;   // final_point
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // source_index, morton_key, out_x, out_y, out_z
  logic                  out_tlast;  // last_result

  morton_scoreboard sort_board;
  bit  quiet_phase;   // no idling on either side near the end of the run
  int  send_gap_pct;  // chance in percent of an idle burst before a transaction
  int  stall_left;
  int  idle_cycles;

  morton_order_point_sort uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // The receiver stalls in random bursts; every accepted result is checked here.
  // The watchdog counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready)
        sort_board.check_point(out_tdata, out_tlast);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("morton_order_point_sort verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One input transaction. in_tvalid is lowered only during an idle burst and at the
  // end of the run, so it stays high across back-to-back transactions.
  task automatic send_command(bit cmd, int x, int y, int z, bit fin);
    if (!quiet_phase && $urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {z, y, x};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sort_board.note_command(cmd, x, y, z, fin);
  endtask

  task automatic load_point(int x, int y, int z, bit fin);
    send_command(CMD_LOAD, x, y, z, fin);
  endtask

  task automatic fetch_points(int n);
    repeat (n) send_command(CMD_FETCH, $urandom, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // Coordinates of several flavors: full range, a tight cluster, one constant, or near the field extremes.
  function automatic int pick_coord(int style, int base);
    case (style)
      0: return $urandom;
      1: return base + $urandom_range(0, 255) - 128;
      2: return base;
      default: return $urandom_range(0, 3) == 0 ? 32'sh80000000 + $urandom_range(0, 3)
                                               : 32'sh7fffffff - $urandom_range(0, 3);
    endcase
  endfunction

  // One set: at times a lone fetch first, then n loads with the last marked final, then
  // fetches sometimes short of n (the next load then starts afresh) and sometimes past it.
  task automatic run_set(int n);
    int sx, sy, sz, bx, by, bz, nf;
    sx = $urandom_range(0, 3); sy = $urandom_range(0, 3); sz = $urandom_range(0, 3);
    bx = $urandom; by = $urandom; bz = $urandom;
    send_gap_pct = $urandom_range(0, 2) == 0 ? 0 : 30;
    if ($urandom_range(0, 9) == 0) fetch_points(1);
    for (int i = 0; i < n; i++)
      load_point(pick_coord(sx, bx), pick_coord(sy, by), pick_coord(sz, bz), i == n - 1);
    case ($urandom_range(0, 5))
      0:       nf = $urandom_range(0, n);
      1:       nf = n + $urandom_range(1, 3);
      default: nf = n;
    endcase
    fetch_points(nf);
  endtask

  initial begin
    sort_board = new();
    quiet_phase = 0;
    send_gap_pct = 30;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_LOAD;
    in_tlast = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A fetch before any sort gives nothing.
    fetch_points(1);
    // Field extremes, a z axis of zero extent, and two identical points
    // whose equal keys must come back in load order.
    load_point(32'sh80000000, 32'sh7fffffff, 0, 1'b0);
    load_point(32'sh7fffffff, 32'sh80000000, 0, 1'b0);
    load_point(-1, 0, 0, 1'b0);
    load_point(-1, 0, 0, 1'b0);
    load_point(32'sh00010000, 32'shffff0000, 0, 1'b1);
    // Past the end gives nothing; final_point on a fetch is ignored.
    send_command(CMD_FETCH, 0, 0, 0, 1'b1);
    fetch_points(6);
    // A single point: every axis has zero extent.
    load_point(32'sh12345678, 32'sh9abcdef0, 32'sh0f0f0f0f, 1'b1);
    fetch_points(2);
    // A load in the middle of fetching drops the rest of the old set.
    load_point(5, 5, 5, 1'b0);
    load_point(1, 1, 1, 1'b1);
    fetch_points(1);
    load_point(7, -7, 7, 1'b0);
    load_point(-7, 7, -7, 1'b1);
    fetch_points(2);

    // Full store: loads past the store size are dropped, the final one still sorts.
    // Only the head of the sorted order is fetched; the next set drops the rest.
    send_gap_pct = 10;
    for (int i = 0; i < 1027; i++)
      load_point($urandom, $urandom, $urandom, i == 1026);
    fetch_points(200);

    // Random small sets.
    for (int s = 0; s < 28; s++) run_set($urandom_range(0, 7) == 0 ? $urandom_range(20, 40)
                                                                   : $urandom_range(1, 12));
    quiet_phase = 1;
    for (int s = 0; s < 8; s++) run_set($urandom_range(1, 10));

    in_tvalid <= 1'b0;
    while (sort_board.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sort_board.errors == 0) begin
      $display("morton_order_point_sort verification clean");
    end else begin
      $display("morton_order_point_sort verification failed");
    end
    $finish;
  end
endmodule
